// ===== hdl/bvl_pkg.sv =====
`default_nettype none
package bvl_pkg;

    localparam int WORD_W    = 24;
    localparam int FRAC_BITS = 16;
    localparam int SQ_STEPS  = 30;
    localparam int Q_BITS    = 25;
    localparam int EM_BITS   = 35;
    localparam int LN_STEPS  = 6;
    localparam int N_TERMS   = 20;

    localparam logic [29:0]       LN2_Q30    = 30'd744261118;
    localparam logic [WORD_W-1:0] WORD_MAX   = 24'hFFFFFF;
    localparam logic [WORD_W-1:0] SOFT_RESET = 24'd24248;

    typedef struct packed {
        logic [WORD_W-1:0] r0g;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] r2;
        logic [WORD_W-1:0] c2;
        logic [WORD_W-1:0] r1;
        logic [WORD_W-1:0] c1;
    } t_bond_in;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic [WORD_W-1:0] len;
        logic              sat;
    } t_r0_res;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0_used;
        logic [WORD_W-1:0] valence;
        logic              sat;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/bvl_r0.sv =====
`default_nettype none
module bvl_r0 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire bvl_pkg::t_bond_in i_bond,
    output bvl_pkg::t_r0_res  o_res
);
    import bvl_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r1;
        logic [WORD_W-1:0] r2;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] r0g;
        logic              cok;
    } t_side;

    typedef struct packed {
        t_side        sd;
        logic [47:0]  p1;
        logic [47:0]  p2;
        logic [47:0]  pc;
        logic [47:0]  a;
        logic [24:0]  csum;
    } t_prod;

    typedef struct packed {
        t_side        sd;
        logic [48:0]  den;
        logic [47:0]  a;
        logic [24:0]  csum;
        logic [59:0]  rem;
        logic [59:0]  root;
    } t_sq;

    typedef struct packed {
        t_side        sd;
        logic [48:0]  den;
        logic [47:0]  a;
        logic [30:0]  dd;
    } t_dd;

    typedef struct packed {
        t_side        sd;
        logic [48:0]  den;
        logic [54:0]  pl;
        logic [54:0]  ph;
    } t_mul;

    typedef struct packed {
        t_side        sd;
        logic [48:0]  den;
        logic [79:0]  num;
    } t_num;

    typedef struct packed {
        t_side        sd;
        logic [48:0]  den;
        logic [79:0]  rem;
        logic [Q_BITS-1:0] q;
        logic         ovf;
    } t_dv;

    t_prod r_prod;
    t_sq   r_sq [SQ_STEPS+1];
    t_dd   r_dd;
    t_mul  r_mul;
    t_num  r_num;
    t_dv   r_dv [Q_BITS+1];
    t_r0_res r_res;

    t_r0_res n_res;

    // One digit of the square root: bit weight 4^(29-j).
    function automatic t_sq sq_step(t_sq s, int j);
        t_sq         o;
        logic [59:0] bitv;
        logic [59:0] trial;
        o     = s;
        bitv  = 60'd1 << (58 - 2 * j);
        trial = s.root + bitv;
        if (s.rem >= trial) begin
            o.rem  = s.rem - trial;
            o.root = (s.root >> 1) + bitv;
        end else begin
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // One quotient bit of the restoring division by den * 64.
    function automatic t_dv dv_step(t_dv s, int i);
        t_dv         o;
        logic [79:0] d;
        o = s;
        d = 80'(s.den) << (6 + i);
        if (s.rem >= d) begin
            o.rem = s.rem - d;
            o.q   = s.q | (Q_BITS'(1) << i);
        end
        return o;
    endfunction

    always_comb begin
        logic [25:0] t;
        logic [25:0] total;
        t = r_dv[Q_BITS].ovf ? (26'd1 << Q_BITS) : 26'(r_dv[Q_BITS].q);
        total = 26'(r_dv[Q_BITS].sd.r1) + 26'(r_dv[Q_BITS].sd.r2) + t;
        n_res.valid = r_dv[Q_BITS].sd.valid;
        n_res.len   = r_dv[Q_BITS].sd.len;
        if (r_dv[Q_BITS].sd.cok && (r_dv[Q_BITS].den != '0)) begin
            if (total > 26'(WORD_MAX)) begin
                n_res.r0  = WORD_MAX;
                n_res.sat = 1'b1;
            end else begin
                n_res.r0  = total[WORD_W-1:0];
                n_res.sat = 1'b0;
            end
        end else begin
            n_res.r0  = r_dv[Q_BITS].sd.r0g;
            n_res.sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.sd.valid <= 1'b0;
            for (int j = 0; j <= SQ_STEPS; j++) r_sq[j].sd.valid <= 1'b0;
            r_dd.sd.valid  <= 1'b0;
            r_mul.sd.valid <= 1'b0;
            r_num.sd.valid <= 1'b0;
            for (int j = 0; j <= Q_BITS; j++) r_dv[j].sd.valid <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_prod.sd.valid <= i_valid;
            r_prod.sd.r1    <= i_bond.r1;
            r_prod.sd.r2    <= i_bond.r2;
            r_prod.sd.len   <= i_bond.len;
            r_prod.sd.r0g   <= i_bond.r0g;
            r_prod.sd.cok   <= (i_bond.r0g == '0) && (i_bond.c1 != '0) && (i_bond.c2 != '0);
            r_prod.p1   <= i_bond.c1 * i_bond.r1;
            r_prod.p2   <= i_bond.c2 * i_bond.r2;
            r_prod.pc   <= i_bond.c1 * i_bond.c2;
            r_prod.a    <= i_bond.r1 * i_bond.r2;
            r_prod.csum <= 25'(i_bond.c1) + 25'(i_bond.c2);

            r_sq[0].sd   <= r_prod.sd;
            r_sq[0].den  <= 49'(r_prod.p1) + 49'(r_prod.p2);
            r_sq[0].a    <= r_prod.a;
            r_sq[0].csum <= r_prod.csum;
            r_sq[0].rem  <= {r_prod.pc, 12'd0};
            r_sq[0].root <= '0;
            for (int j = 0; j < SQ_STEPS; j++) r_sq[j+1] <= sq_step(r_sq[j], j);

            r_dd.sd  <= r_sq[SQ_STEPS].sd;
            r_dd.den <= r_sq[SQ_STEPS].den;
            r_dd.a   <= r_sq[SQ_STEPS].a;
            r_dd.dd  <= {r_sq[SQ_STEPS].csum, 6'd0} - {r_sq[SQ_STEPS].root[29:0], 1'b0};

            // The 48 by 31 bit product is split into two halves of r1*r2.
            r_mul.sd  <= r_dd.sd;
            r_mul.den <= r_dd.den;
            r_mul.pl  <= r_dd.a[23:0] * r_dd.dd;
            r_mul.ph  <= r_dd.a[47:24] * r_dd.dd;

            r_num.sd  <= r_mul.sd;
            r_num.den <= r_mul.den;
            r_num.num <= 80'(r_mul.pl) + (80'(r_mul.ph) << 24) + (80'(r_mul.den) << 5);

            r_dv[0].sd  <= r_num.sd;
            r_dv[0].den <= r_num.den;
            r_dv[0].rem <= r_num.num;
            r_dv[0].q   <= '0;
            r_dv[0].ovf <= r_num.num >= (80'(r_num.den) << (6 + Q_BITS));
            for (int j = 0; j < Q_BITS; j++) r_dv[j+1] <= dv_step(r_dv[j], Q_BITS - 1 - j);

            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== hdl/bvl_val.sv =====
`default_nettype none
module bvl_val (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [bvl_pkg::WORD_W-1:0] i_b,
    input  wire bvl_pkg::t_r0_res i_res,
    output bvl_pkg::t_result o_out
);
    import bvl_pkg::*;

    localparam logic [6:0] SAT_K   = 7'(WORD_W - FRAC_BITS);
    localparam logic [6:0] ZERO_K  = 7'(FRAC_BITS + 2);
    localparam logic [6:0] SH_BASE = 7'(30 - FRAC_BITS);
    localparam int         EX_LAST = 3 * N_TERMS;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic              r0sat;
        logic              neg;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] b;
    } t_va;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic              r0sat;
        logic              neg;
        logic              big;
        logic [WORD_W-1:0] b;
        logic [58:0]       rem;
        logic [EM_BITS-1:0] q;
    } t_ed;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic              r0sat;
        logic              neg;
        logic              big;
        logic [EM_BITS-1:0] rem;
        logic [LN_STEPS-1:0] q;
    } t_ln;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic              r0sat;
        logic              satv;
        logic              zerov;
        logic [4:0]        sh;
        logic [29:0]       f;
        logic [30:0]       term;
        logic [31:0]       sum;
        logic [30:0]       p;
        logic [63:0]       m;
    } t_ex;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] r0;
        logic              r0sat;
        logic              satv;
        logic              zerov;
        logic [4:0]        sh;
        logic [31:0]       x;
    } t_fin;

    t_va     r_va;
    t_ed     r_ed [EM_BITS+2];
    t_ln     r_ln [LN_STEPS+1];
    t_ex     r_ex [EX_LAST+1];
    t_fin    r_fa;
    t_result r_out;

    t_ex     n_kf;
    t_result n_out;

    // floor(2^32 / n) for the series divisors.
    function automatic logic [32:0] recip_of(int n);
        logic [32:0] rc;
        case (n)
            1:       rc = 33'd4294967296;
            2:       rc = 33'd2147483648;
            3:       rc = 33'd1431655765;
            4:       rc = 33'd1073741824;
            5:       rc = 33'd858993459;
            6:       rc = 33'd715827882;
            7:       rc = 33'd613566756;
            8:       rc = 33'd536870912;
            9:       rc = 33'd477218588;
            10:      rc = 33'd429496729;
            11:      rc = 33'd390451572;
            12:      rc = 33'd357913941;
            13:      rc = 33'd330382099;
            14:      rc = 33'd306783378;
            15:      rc = 33'd286331153;
            16:      rc = 33'd268435456;
            17:      rc = 33'd252645135;
            18:      rc = 33'd238609294;
            19:      rc = 33'd226050910;
            20:      rc = 33'd214748364;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    function automatic t_ed ed_step(t_ed s, int i);
        t_ed         o;
        logic [58:0] d;
        o = s;
        d = 59'(s.b) << i;
        if (s.rem >= d) begin
            o.rem = s.rem - d;
            o.q   = s.q | (EM_BITS'(1) << i);
        end
        return o;
    endfunction

    function automatic t_ed ed_big(t_ed s);
        t_ed o;
        o     = s;
        o.big = s.rem >= (59'(s.b) << EM_BITS);
        return o;
    endfunction

    function automatic t_ln ln_step(t_ln s, int i);
        t_ln         o;
        logic [35:0] d;
        o = s;
        d = 36'(LN2_Q30) << i;
        if ({1'b0, s.rem} >= d) begin
            o.rem = EM_BITS'({1'b0, s.rem} - d);
            o.q   = s.q | (LN_STEPS'(1) << i);
        end
        return o;
    endfunction

    // Series term, first part: term * f, and the running sum takes the previous term.
    function automatic t_ex ex_mul(t_ex s);
        t_ex         o;
        logic [60:0] prod;
        o     = s;
        prod  = s.term * s.f;
        o.p   = prod[60:30];
        o.sum = s.sum + 32'(s.term);
        return o;
    endfunction

    function automatic t_ex ex_rec(t_ex s, logic [32:0] rc);
        t_ex o;
        o   = s;
        o.m = 64'(s.p) * 64'(rc);
        return o;
    endfunction

    // Quotient estimate by the reciprocal; it is exact or one too small.
    function automatic t_ex ex_corr(t_ex s, int n);
        t_ex         o;
        logic [30:0] q0;
        logic [35:0] back;
        logic [35:0] rr;
        o    = s;
        q0   = s.m[62:32];
        back = 36'(q0) * 36'(n);
        rr   = 36'(s.p) - back;
        o.term = (rr >= 36'(n)) ? q0 + 31'd1 : q0;
        return o;
    endfunction

    always_comb begin
        logic [6:0] kk;
        logic       nz;
        t_ln        s;
        s  = r_ln[LN_STEPS];
        nz = s.rem != '0;
        kk = 7'(s.q) + 7'(nz);
        n_kf       = '0;
        n_kf.valid = s.valid;
        n_kf.r0    = s.r0;
        n_kf.r0sat = s.r0sat;
        n_kf.term  = 31'd1 << 30;
        n_kf.f     = (s.neg && nz) ? LN2_Q30 - s.rem[29:0] : s.rem[29:0];
        if (s.r0 == '0) begin
            n_kf.zerov = 1'b1;
        end else if (s.big) begin
            n_kf.zerov = s.neg;
            n_kf.satv  = !s.neg;
        end else if (!s.neg) begin
            n_kf.satv = 7'(s.q) >= SAT_K;
            n_kf.sh   = 5'(SH_BASE - 7'(s.q));
        end else begin
            n_kf.zerov = kk >= ZERO_K;
            n_kf.sh    = 5'(SH_BASE + kk);
        end
    end

    always_comb begin
        logic [32:0] rnd;
        rnd = ({1'b0, r_fa.x} + (33'd1 << (r_fa.sh - 5'd1))) >> r_fa.sh;
        n_out.valid   = r_fa.valid;
        n_out.r0_used = r_fa.r0;
        if (r_fa.satv) begin
            n_out.valence = WORD_MAX;
            n_out.sat     = 1'b1;
        end else if (r_fa.zerov) begin
            n_out.valence = '0;
            n_out.sat     = r_fa.r0sat;
        end else if (rnd > 33'(WORD_MAX)) begin
            n_out.valence = WORD_MAX;
            n_out.sat     = 1'b1;
        end else begin
            n_out.valence = rnd[WORD_W-1:0];
            n_out.sat     = r_fa.r0sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va.valid <= 1'b0;
            for (int j = 0; j <= EM_BITS + 1; j++) r_ed[j].valid <= 1'b0;
            for (int j = 0; j <= LN_STEPS; j++) r_ln[j].valid <= 1'b0;
            for (int j = 0; j <= EX_LAST; j++) r_ex[j].valid <= 1'b0;
            r_fa.valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_va.valid <= i_res.valid;
            r_va.r0    <= i_res.r0;
            r_va.r0sat <= i_res.sat;
            r_va.neg   <= i_res.r0 < i_res.len;
            r_va.mag   <= (i_res.r0 < i_res.len) ? i_res.len - i_res.r0 : i_res.r0 - i_res.len;
            r_va.b     <= (i_b == '0) ? WORD_W'(1) : i_b;

            r_ed[0].valid <= r_va.valid;
            r_ed[0].r0    <= r_va.r0;
            r_ed[0].r0sat <= r_va.r0sat;
            r_ed[0].neg   <= r_va.neg;
            r_ed[0].big   <= 1'b0;
            r_ed[0].b     <= r_va.b;
            r_ed[0].rem   <= {5'd0, r_va.mag, 30'd0} + 59'(r_va.b >> 1);
            r_ed[0].q     <= '0;

            // Only the quotient range that can change the outcome is resolved.
            r_ed[1] <= ed_big(r_ed[0]);
            for (int j = 0; j < EM_BITS; j++) r_ed[j+2] <= ed_step(r_ed[j+1], EM_BITS - 1 - j);

            r_ln[0].valid <= r_ed[EM_BITS+1].valid;
            r_ln[0].r0    <= r_ed[EM_BITS+1].r0;
            r_ln[0].r0sat <= r_ed[EM_BITS+1].r0sat;
            r_ln[0].neg   <= r_ed[EM_BITS+1].neg;
            r_ln[0].big   <= r_ed[EM_BITS+1].big;
            r_ln[0].rem   <= r_ed[EM_BITS+1].q;
            r_ln[0].q     <= '0;
            for (int j = 0; j < LN_STEPS; j++) r_ln[j+1] <= ln_step(r_ln[j], LN_STEPS - 1 - j);

            r_ex[0] <= n_kf;
            for (int n = 0; n < N_TERMS; n++) begin
                r_ex[3*n+1] <= ex_mul(r_ex[3*n]);
                r_ex[3*n+2] <= ex_rec(r_ex[3*n+1], recip_of(n + 1));
                r_ex[3*n+3] <= ex_corr(r_ex[3*n+2], n + 1);
            end

            r_fa.valid <= r_ex[EX_LAST].valid;
            r_fa.r0    <= r_ex[EX_LAST].r0;
            r_fa.r0sat <= r_ex[EX_LAST].r0sat;
            r_fa.satv  <= r_ex[EX_LAST].satv;
            r_fa.zerov <= r_ex[EX_LAST].zerov;
            r_fa.sh    <= r_ex[EX_LAST].sh;
            r_fa.x     <= r_ex[EX_LAST].sum + 32'(r_ex[EX_LAST].term);

            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ===== hdl/bond_length_to_valence.sv =====
`default_nettype none
// Bond valence from bond length. Each item gives two atoms (coefficient and radius), a bond
// length and an optional R0; R0 is computed from the atoms when the given R0 is zero and both
// coefficients are nonzero, and the result is R0 and exp((R0 - length) / b), all in unsigned
// Q8.16. The pipeline takes one item per clock while s_axis_tready is high; its depth is set
// by the bit-per-stage square root, the restoring dividers and the three stages per term of
// the twenty-term exponential series. An output skid register lets the pipeline keep taking
// items after the output stalls, until a result waits in the skid register. The softness b
// is written with i_cfg_wen and should only be changed while no item is in flight.
module bond_length_to_valence (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wen,
    input  wire logic [23:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coef_first, radius_first, coef_second, radius_second, bond_length, r0_given
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // r0_used, valence_out
    output logic [47:0]       m_axis_tdata,
    // saturated
    output logic [0:0]        m_axis_tuser
);
    import bvl_pkg::*;

    logic [WORD_W-1:0] r_b;
    logic              r_ov;
    t_result           r_od;
    logic              r_sv;
    t_result           r_sd;

    logic    en;
    t_r0_res r0_res;
    t_result vres;

    assign en = !r_sv;

    bvl_r0 u_r0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_bond  (t_bond_in'(s_axis_tdata)),
        .o_res   (r0_res)
    );

    bvl_val u_val (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_b     (r_b),
        .i_res   (r0_res),
        .o_out   (vres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= SOFT_RESET;
        end else if (i_cfg_wen) begin
            r_b <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (en) begin
            if (!r_ov || m_axis_tready) begin
                r_ov <= vres.valid;
                r_od <= vres;
            end else if (vres.valid) begin
                r_sv <= 1'b1;
                r_sd <= vres;
            end
        end else if (m_axis_tready) begin
            r_od <= r_sd;
            r_sv <= 1'b0;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_od.valence, r_od.r0_used};
    assign m_axis_tuser  = r_od.sat;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid item held without an output item");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !m_axis_tready))
        else $error("skid filled while output was free");

    a_zero_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od.r0_used != '0 || r_od.valence == '0))
        else $error("nonzero valence with zero R0");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
    import bvl_pkg::*;

    localparam int LN2_I     = 744261118;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [23:0] r0_used;
        logic [23:0] valence;
        logic        sat;
    } t_bond_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [23:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    bond_length_to_valence u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_bond_in  pending_bonds[$];
    t_bond_out expected_bonds[$];
    logic [23:0] softness = SOFT_RESET;
    bit  quiet_tail = 1'b0;
    int  errors = 0;
    int  idle_cycles = 0;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_bond_out bond_valence(t_bond_in it, logic [23:0] b_in);
        t_bond_out res;
        logic [63:0]  c1, r1, c2, r2, len, r0, den, qs, dd, b, mag, em, q, rm, f, x, term, v;
        logic [127:0] num, t;
        longint k, sh;
        bit neg;
        c1 = it.c1; r1 = it.r1; c2 = it.c2; r2 = it.r2; len = it.len; r0 = it.r0g;
        res = '0;
        if (r0 == 0 && c1 != 0 && c2 != 0) begin
            den = c1 * r1 + c2 * r2;
            if (den != 0) begin
                qs = isqrt64((c1 * c2) << 12);
                dd = ((c1 + c2) << 6) - 2 * qs;
                num = 128'(r1 * r2) * 128'(dd) + 128'((den << 6) >> 1);
                t = num / 128'(den << 6);
                if (t > 128'(64'd1 << 25)) t = 128'(64'd1 << 25);
                r0 = r1 + r2 + t[63:0];
                if (r0 > 64'hFFFFFF) begin
                    r0 = 64'hFFFFFF;
                    res.sat = 1'b1;
                end
            end
        end
        res.r0_used = r0[23:0];
        if (r0 == 0) return res;
        b = (b_in == 0) ? 64'd1 : 64'(b_in);
        neg = r0 < len;
        mag = neg ? len - r0 : r0 - len;
        em = ((mag << 30) + (b >> 1)) / b;
        q = em / LN2_I;
        rm = em % LN2_I;
        if (!neg) begin
            k = q; f = rm;
        end else if (rm == 0) begin
            k = -longint'(q); f = 0;
        end else begin
            k = -longint'(q) - 1; f = LN2_I - rm;
        end
        if (k + FRAC_BITS >= 24) begin
            res.valence = WORD_MAX;
            res.sat = 1'b1;
            return res;
        end
        sh = 30 - FRAC_BITS - k;
        if (sh >= 32) return res;
        x = 64'd1 << 30;
        term = x;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * f) >> 30) / n;
            x = x + term;
        end
        v = (x + (64'd1 << (sh - 1))) >> sh;
        if (v > 64'hFFFFFF) begin
            v = 64'hFFFFFF;
            res.sat = 1'b1;
        end
        res.valence = v[23:0];
        return res;
    endfunction

    function automatic logic [23:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 24'h0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly realistic atoms: coefficients and radii near one, bond length near R0; one item in four is random words.
    function automatic t_bond_in rand_bond();
        t_bond_in it;
        if ($urandom_range(0, 3) == 0) begin
            it = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
        end else begin
            it.c1 = 24'($urandom_range(1, 24'h40000));
            it.c2 = 24'($urandom_range(1, 24'h40000));
            it.r1 = 24'($urandom_range(0, 24'h30000));
            it.r2 = 24'($urandom_range(0, 24'h30000));
            it.len = 24'($urandom_range(24'h8000, 24'h50000));
            it.r0g = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'h40000)) : 24'h0;
        end
        return it;
    endfunction

    // Driver: bursts of idling on the valid side.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_bonds.push_back(bond_valence(s_axis_tdata, softness));
                void'(pending_bonds.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                    src_gap <= $urandom_range(0, 13);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bonds.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_bonds[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results and stalls the output side in bursts.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_bond_out got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser[0]};
                if (expected_bonds.size() == 0) begin
                    $error("result with no item outstanding: %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_bonds.pop_front();
                    if (got.r0_used !== want.r0_used) begin
                        $error("r0_used expected %h got %h", want.r0_used, got.r0_used);
                        errors++;
                    end
                    if (got.valence !== want.valence) begin
                        $error("valence_out expected %h got %h", want.valence, got.valence);
                        errors++;
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturated expected %b got %b", want.sat, got.sat);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                sink_gap <= $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_bonds.size() != 0 || expected_bonds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_softness(logic [23:0] value);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= value;
        softness = value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    initial begin
        t_bond_in it;
        logic [23:0] soft_set[5] = '{24'd24248, 24'd1, 24'hFFFFFF, 24'd0, 24'd6554};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: given R0, unknown coefficients, zero denominator, huge R0, extremes.
        pending_bonds.push_back({24'h018000, 24'h018000, 24'h0, 24'h0, 24'h0, 24'h0});
        pending_bonds.push_back({24'h0, 24'h020000, 24'h010000, 24'h010000, 24'h010000, 24'h0});
        pending_bonds.push_back({24'h0, 24'h020000, 24'h010000, 24'h0, 24'h010000, 24'h010000});
        pending_bonds.push_back({24'h0, 24'h020000, 24'h0, 24'h010000, 24'h0, 24'h010000});
        pending_bonds.push_back({24'h0, 24'h020000, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'hFFFFFF});
        pending_bonds.push_back({24'h0, 24'h0, 24'h900000, 24'h000001, 24'h900000, 24'h000001});
        pending_bonds.push_back({24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0});
        pending_bonds.push_back({24'h000001, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0});
        pending_bonds.push_back({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF});
        pending_bonds.push_back({24'h0, 24'h01C000, 24'h014000, 24'h020000, 24'h012000,
                                 24'h030000});
        pending_bonds.push_back({24'h0, 24'h0, 24'h000001, 24'h000001, 24'h000001, 24'h000001});
        pending_bonds.push_back({24'h020000, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0});
        wait_idle();

        foreach (soft_set[s]) begin
            write_softness(soft_set[s]);
            if (s == 4) quiet_tail = 1'b0;
            for (int n = 0; n < 300; n++) begin
                it = rand_bond();
                pending_bonds.push_back(it);
            end
            if (s == 4) begin
                while (pending_bonds.size() > 80) @(posedge i_clk);
                quiet_tail = 1'b1;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/bvl_pkg.sv
hdl/bvl_r0.sv
hdl/bvl_val.sv
hdl/bond_length_to_valence.sv
tb/testbench.sv
